// ===== rtl/core/escu_pkg.sv =====
// Shared types and constants for the environmental sensor compensation unit.
// Used by escu_temp, escu_press, escu_hum and the top level; no dependencies.
package escu_pkg;

    // Register indices (byte address = 8 * index).
    localparam logic [2:0] REG_TEMP_CALIB    = 3'd0;
    localparam logic [2:0] REG_PRESS_CALIB_A = 3'd1;
    localparam logic [2:0] REG_PRESS_CALIB_B = 3'd2;
    localparam logic [2:0] REG_PRESS_HUM     = 3'd3;
    localparam logic [2:0] REG_HUM_CALIB     = 3'd4;

    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int DIV_W     = 32;

    // Latencies in register stages.
    localparam int TEMP_LAT  = 4;
    localparam int PRESS_LAT = 8 + DIV_W + 3;
    localparam int HUM_CORE  = 10;
    localparam int HUM_PAD   = PRESS_LAT - HUM_CORE;

    localparam logic signed [31:0] HUM_MAX_ACC = 32'sd419430400;
    localparam logic [31:0]        PRESS_MAX   = 32'd262143;

    // Calibration words, unpacked to 32 bits; t1, p1 and h1 zero extended, the rest sign extended.
    typedef struct packed {
        logic signed [31:0] t1, t2, t3;
        logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [31:0] h1, h2, h3, h4, h5, h6;
    } t_calib;

endpackage

// ===== rtl/core/escu_if.sv =====
// Item channel interfaces for the compensation unit.
// Depends on nothing; payload widths follow the field list.
interface escu_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
    modport source(output valid, raw_temp, raw_press, raw_hum, input ready);
    modport sink(input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface escu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temp;
    logic signed [15:0] temp_centi;
    logic        [17:0] press_pa;
    logic               press_invalid;
    logic        [16:0] hum_q10;
    modport source(output valid, fine_temp, temp_centi, press_pa, press_invalid, hum_q10,
                   input ready);
    modport sink(input valid, fine_temp, temp_centi, press_pa, press_invalid, hum_q10,
                 output ready);
endinterface

// ===== rtl/core/escu_temp.sv =====
// Fine temperature pipeline, four stages.
// Depends on escu_pkg.
module escu_temp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [19:0]          i_raw_temp,
    input  logic [19:0]          i_raw_press,
    input  logic [15:0]          i_raw_hum,
    input  escu_pkg::t_calib     i_cal,
    output logic                 o_vld,
    output logic signed [31:0]   o_tfine,
    output logic [19:0]          o_raw_press,
    output logic [15:0]          o_raw_hum
);
    logic [escu_pkg::TEMP_LAT-1:0] r_vld;
    logic signed [31:0] r_x1, r_d, r_m1, r_dd, r_a, r_m2, r_tfine;
    logic [19:0] r_rp [0:escu_pkg::TEMP_LAT-1];
    logic [15:0] r_rh [0:escu_pkg::TEMP_LAT-1];
    logic signed [31:0] adc_t;

    assign adc_t = $signed({12'd0, i_raw_temp});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[escu_pkg::TEMP_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= (adc_t >>> 3) - (i_cal.t1 <<< 1);
            r_d     <= (adc_t >>> 4) - i_cal.t1;
            r_m1    <= r_x1 * i_cal.t2;
            r_dd    <= r_d * r_d;
            r_a     <= r_m1 >>> 11;
            r_m2    <= (r_dd >>> 12) * i_cal.t3;
            r_tfine <= r_a + (r_m2 >>> 14);
            r_rp[0] <= i_raw_press;
            r_rh[0] <= i_raw_hum;
            for (int k = 1; k < escu_pkg::TEMP_LAT; k++) begin
                r_rp[k] <= r_rp[k-1];
                r_rh[k] <= r_rh[k-1];
            end
        end
    end

    assign o_vld       = r_vld[escu_pkg::TEMP_LAT-1];
    assign o_tfine     = r_tfine;
    assign o_raw_press = r_rp[escu_pkg::TEMP_LAT-1];
    assign o_raw_hum   = r_rh[escu_pkg::TEMP_LAT-1];
endmodule

// ===== rtl/core/escu_press.sv =====
// Pressure pipeline: eight setup stages, a one-bit-per-stage divider, three
// correction stages. Depends on escu_pkg.
module escu_press (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_tfine,
    input  logic [19:0]        i_raw_press,
    input  escu_pkg::t_calib   i_cal,
    output logic [17:0]        o_press,
    output logic               o_invalid
);
    localparam int DW = escu_pkg::DIV_W;

    logic signed [31:0] r1_v1, r1_q, r2_qq, r2_m5, r2_m2, r3_v2a, r3_m3, r3_m5, r3_m2;
    logic signed [31:0] r4_v2, r4_v1b, r5_prod, r5_v2, r6_div, r6_t, r7_div;
    logic [31:0] r7_pm;
    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap;
    logic signed [31:0] v2_sum, v1_sum, adc_p;

    // divider pipe, index 0 is loaded by stage 8
    logic [DW-1:0] r_rem [0:DW];
    logic [DW-1:0] r_dvd [0:DW];
    logic [DW-1:0] r_quo [0:DW];
    logic [DW-1:0] r_dsr [0:DW];
    logic          r_mode [0:DW];
    logic          r_inv  [0:DW];

    logic [31:0] q_p, d1_p, d2_p, d1_sq;
    logic signed [31:0] d1_w2m, d2_w1m, d2_w2, corr, pf;
    logic d1_inv, d2_inv, r_inv_out;
    logic [17:0] r_press;

    assign v2_sum = r3_v2a + (r3_m5 <<< 1);
    assign v1_sum = (r3_m3 >>> 3) + (r3_m2 >>> 1);
    assign adc_p  = $signed({12'd0, r5_ap});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v1  <= (i_tfine >>> 1) - 32'sd64000;
            r1_q   <= ((i_tfine >>> 1) - 32'sd64000) >>> 2;
            r1_ap  <= i_raw_press;
            r2_qq  <= r1_q * r1_q;
            r2_m5  <= r1_v1 * i_cal.p5;
            r2_m2  <= i_cal.p2 * r1_v1;
            r2_ap  <= r1_ap;
            r3_v2a <= (r2_qq >>> 11) * i_cal.p6;
            r3_m3  <= i_cal.p3 * (r2_qq >>> 13);
            r3_m5  <= r2_m5;
            r3_m2  <= r2_m2;
            r3_ap  <= r2_ap;
            r4_v2  <= (v2_sum >>> 2) + (i_cal.p4 <<< 16);
            r4_v1b <= v1_sum >>> 18;
            r4_ap  <= r3_ap;
            r5_prod <= (32'sd32768 + r4_v1b) * i_cal.p1;
            r5_v2  <= r4_v2;
            r5_ap  <= r4_ap;
            r6_div <= r5_prod >>> 15;
            r6_t   <= (32'sd1048576 - adc_p) - (r5_v2 >>> 12);
            r7_pm  <= $unsigned(r6_t) * 32'd3125;
            r7_div <= r6_div;
            // below 2^31 the dividend is doubled first, else the quotient is
            r_mode[0] <= r7_pm[31];
            r_dvd[0]  <= r7_pm[31] ? r7_pm : {r7_pm[30:0], 1'b0};
            r_dsr[0]  <= $unsigned(r7_div);
            r_inv[0]  <= (r7_div == 32'sd0);
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [DW:0] cat;
        logic        ge;
        assign cat = {r_rem[k], r_dvd[k][DW-1]};
        assign ge  = (cat >= {1'b0, r_dsr[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? DW'(cat - {1'b0, r_dsr[k]}) : cat[DW-1:0];
                r_quo[k+1]  <= {r_quo[k][DW-2:0], ge};
                r_dvd[k+1]  <= {r_dvd[k][DW-2:0], 1'b0};
                r_dsr[k+1]  <= r_dsr[k];
                r_mode[k+1] <= r_mode[k];
                r_inv[k+1]  <= r_inv[k];
            end
        end
    end

    assign q_p  = r_mode[DW] ? {r_quo[DW][30:0], 1'b0} : r_quo[DW];
    assign corr = (((d2_w1m >>> 12) + d2_w2) + i_cal.p7) >>> 4;
    assign pf   = $signed(d2_p) + corr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            d1_sq  <= (q_p >> 3) * (q_p >> 3);
            d1_w2m <= $signed(q_p >> 2) * i_cal.p8;
            d1_p   <= q_p;
            d1_inv <= r_inv[DW];
            d2_w1m <= i_cal.p9 * $signed(d1_sq >> 13);
            d2_w2  <= d1_w2m >>> 13;
            d2_p   <= d1_p;
            d2_inv <= d1_inv;
            if (d2_inv) begin
                r_press <= '0;
            end else if ($unsigned(pf) > escu_pkg::PRESS_MAX) begin
                r_press <= escu_pkg::PRESS_MAX[17:0];
            end else begin
                r_press <= pf[17:0];
            end
            r_inv_out <= d2_inv;
        end
    end

    assign o_press   = r_press;
    assign o_invalid = r_inv_out;
endmodule

// ===== rtl/core/escu_hum.sv =====
// Humidity and temperature scaling pipeline, padded to the pressure latency;
// carries the valid bits and fine temperature. Depends on escu_pkg.
module escu_hum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [31:0] i_tfine,
    input  logic [15:0]        i_raw_hum,
    input  escu_pkg::t_calib   i_cal,
    output logic               o_vld,
    output logic signed [31:0] o_tfine,
    output logic signed [15:0] o_tc,
    output logic [16:0]        o_hum
);
    localparam int NC = escu_pkg::HUM_CORE;
    localparam int NP = escu_pkg::HUM_PAD;

    logic [NC-1:0]      r_vld;
    logic signed [31:0] r_tf [0:NC-1];
    logic signed [15:0] r_tc [0:NC-1];
    logic signed [31:0] r1_h, r2_l0, r2_m5, r2_r0, r2_s0, r3_l, r3_r, r3_s;
    logic signed [31:0] r4_rs, r5_rh, r6_r3, r7_hm, r8_hh, r8_hm, r9_x, r9_hm;
    logic signed [31:0] r4_l, r5_l, r6_l, hf, hs;
    logic [15:0]        r1_ah;
    logic [16:0]        r_hq;
    logic signed [34:0] tc_ext, tc_sh;
    logic signed [15:0] tc_sat;

    logic               r_pd_vld [0:NP-1];
    logic signed [31:0] r_pd_tf  [0:NP-1];
    logic signed [15:0] r_pd_tc  [0:NP-1];
    logic [16:0]        r_pd_h   [0:NP-1];

    // (tfine*5 + 128) >> 8 without wrap, then saturate
    assign tc_ext = 35'(i_tfine) + (35'(i_tfine) <<< 2) + 35'sd128;
    assign tc_sh  = tc_ext >>> 8;
    always_comb begin
        if (tc_sh > 35'sd32767)       tc_sat = 16'sh7fff;
        else if (tc_sh < -35'sd32768) tc_sat = 16'sh8000;
        else                          tc_sat = tc_sh[15:0];
    end

    assign hs = r7_hm >>> 15;
    assign hf = r9_hm - (r9_x >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NC-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tf[0] <= i_tfine;
            r_tc[0] <= tc_sat;
            for (int k = 1; k < NC; k++) begin
                r_tf[k] <= r_tf[k-1];
                r_tc[k] <= r_tc[k-1];
            end
            r1_h  <= i_tfine - 32'sd76800;
            r1_ah <= i_raw_hum;
            r2_l0 <= $signed({2'd0, r1_ah, 14'd0}) - (i_cal.h4 <<< 20);
            r2_m5 <= i_cal.h5 * r1_h;
            r2_r0 <= r1_h * i_cal.h6;
            r2_s0 <= r1_h * i_cal.h3;
            r3_l  <= ((r2_l0 - r2_m5) + 32'sd16384) >>> 15;
            r3_r  <= r2_r0 >>> 10;
            r3_s  <= (r2_s0 >>> 11) + 32'sd32768;
            r4_rs <= r3_r * r3_s;
            r4_l  <= r3_l;
            r5_rh <= ((r4_rs >>> 10) + 32'sd2097152) * i_cal.h2;
            r5_l  <= r4_l;
            r6_r3 <= (r5_rh + 32'sd8192) >>> 14;
            r6_l  <= r5_l;
            r7_hm <= r6_l * r6_r3;
            r8_hh <= hs * hs;
            r8_hm <= r7_hm;
            r9_x  <= (r8_hh >>> 7) * i_cal.h1;
            r9_hm <= r8_hm;
            if (hf < 32'sd0)                     r_hq <= '0;
            else if (hf > escu_pkg::HUM_MAX_ACC) r_hq <= escu_pkg::HUM_MAX_ACC[28:12];
            else                                 r_hq <= hf[28:12];
        end
    end

    // alignment to the pressure path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NP; k++) r_pd_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_pd_vld[0] <= r_vld[NC-1];
            for (int k = 1; k < NP; k++) r_pd_vld[k] <= r_pd_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd_tf[0] <= r_tf[NC-1];
            r_pd_tc[0] <= r_tc[NC-1];
            r_pd_h[0]  <= r_hq;
            for (int k = 1; k < NP; k++) begin
                r_pd_tf[k] <= r_pd_tf[k-1];
                r_pd_tc[k] <= r_pd_tc[k-1];
                r_pd_h[k]  <= r_pd_h[k-1];
            end
        end
    end

    assign o_vld   = r_pd_vld[NP-1];
    assign o_tfine = r_pd_tf[NP-1];
    assign o_tc    = r_pd_tc[NP-1];
    assign o_hum   = r_pd_h[NP-1];
endmodule

// ===== rtl/core/env_sensor_compensation_unit.sv =====
// Top level of the environmental sensor compensation unit: APB calibration
// registers and the temperature, pressure and humidity pipelines.
// Depends on escu_pkg, escu_if, escu_temp, escu_press, escu_hum.
//
//   channel  dir  handshake       payload
//   i_in     in   valid/ready     raw_temp, raw_press, raw_hum
//   o_out    out  valid/ready     fine_temp, temp_centi, press_pa, press_invalid, hum_q10
//   apb      in   psel/penable    5 calibration registers at 8*index, 64-bit data
//
// One item enters per cycle while the pipe advances; each result passes 4 fine
// temperature stages, then the pressure path with its 32-stage restoring
// divider. Reset clears only the valid bits and calibration registers.
// The whole pipe advances whenever the output register is empty or being
// taken, so a stall freezes every stage in place and nothing is lost.
module env_sensor_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    escu_in_if.sink                       i_in,
    escu_out_if.source                    o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [escu_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [escu_pkg::DATA_W-1:0]   i_pwdata,
    output logic [escu_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [47:0] r_press_hum;
    logic [31:0] r_hum_cal;

    escu_pkg::t_calib cal;

    logic               en;
    logic               t_vld;
    logic signed [31:0] t_tfine;
    logic [19:0]        t_rp;
    logic [15:0]        t_rh;
    logic [2:0]         reg_idx;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[5:3];

    // calibration write, taken in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal  <= '0;
            r_press_a   <= '0;
            r_press_b   <= '0;
            r_press_hum <= '0;
            r_hum_cal   <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (reg_idx)
                escu_pkg::REG_TEMP_CALIB:    r_temp_cal  <= i_pwdata[47:0];
                escu_pkg::REG_PRESS_CALIB_A: r_press_a   <= i_pwdata;
                escu_pkg::REG_PRESS_CALIB_B: r_press_b   <= i_pwdata;
                escu_pkg::REG_PRESS_HUM:     r_press_hum <= i_pwdata[47:0];
                escu_pkg::REG_HUM_CALIB:     r_hum_cal   <= i_pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            escu_pkg::REG_TEMP_CALIB:    o_prdata = {16'd0, r_temp_cal};
            escu_pkg::REG_PRESS_CALIB_A: o_prdata = r_press_a;
            escu_pkg::REG_PRESS_CALIB_B: o_prdata = r_press_b;
            escu_pkg::REG_PRESS_HUM:     o_prdata = {16'd0, r_press_hum};
            escu_pkg::REG_HUM_CALIB:     o_prdata = {32'd0, r_hum_cal};
            default:                     o_prdata = '0;
        endcase
    end

    // field unpacking to 32 bits; t1, p1 and h1 zero extended, the rest sign extended
    always_comb begin
        cal.t1 = $signed({16'd0, r_temp_cal[15:0]});
        cal.t2 = 32'($signed(r_temp_cal[31:16]));
        cal.t3 = 32'($signed(r_temp_cal[47:32]));
        cal.p1 = $signed({16'd0, r_press_a[15:0]});
        cal.p2 = 32'($signed(r_press_a[31:16]));
        cal.p3 = 32'($signed(r_press_a[47:32]));
        cal.p4 = 32'($signed(r_press_a[63:48]));
        cal.p5 = 32'($signed(r_press_b[15:0]));
        cal.p6 = 32'($signed(r_press_b[31:16]));
        cal.p7 = 32'($signed(r_press_b[47:32]));
        cal.p8 = 32'($signed(r_press_b[63:48]));
        cal.p9 = 32'($signed(r_press_hum[15:0]));
        cal.h1 = $signed({24'd0, r_press_hum[23:16]});
        cal.h2 = 32'($signed(r_press_hum[39:24]));
        cal.h3 = 32'($signed(r_press_hum[47:40]));
        cal.h4 = 32'($signed(r_hum_cal[11:0]));
        cal.h5 = 32'($signed(r_hum_cal[23:12]));
        cal.h6 = 32'($signed(r_hum_cal[31:24]));
    end

    // global advance: output register free or draining
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    escu_temp u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (i_in.valid),
        .i_raw_temp  (i_in.raw_temp),
        .i_raw_press (i_in.raw_press),
        .i_raw_hum   (i_in.raw_hum),
        .i_cal       (cal),
        .o_vld       (t_vld),
        .o_tfine     (t_tfine),
        .o_raw_press (t_rp),
        .o_raw_hum   (t_rh)
    );

    escu_press u_press (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_tfine     (t_tfine),
        .i_raw_press (t_rp),
        .i_cal       (cal),
        .o_press     (o_out.press_pa),
        .o_invalid   (o_out.press_invalid)
    );

    escu_hum u_hum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (t_vld),
        .i_tfine   (t_tfine),
        .i_raw_hum (t_rh),
        .i_cal     (cal),
        .o_vld     (o_out.valid),
        .o_tfine   (o_out.fine_temp),
        .o_tc      (o_out.temp_centi),
        .o_hum     (o_out.hum_q10)
    );
endmodule

// ===== rtl/core/escu_chk.sv =====
// Port-level checker for the compensation unit, bound to the top level.
// Depends on the top level's channel signals only.
module escu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [17:0] i_press_pa,
    input logic        i_press_invalid,
    input logic [16:0] i_hum_q10
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready not tied to output drain");

    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_press_invalid |-> i_press_pa == 18'd0)
        else $error("invalid pressure not zero");

    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hum_q10 <= 17'd102400)
        else $error("humidity out of range");
endmodule

bind env_sensor_compensation_unit escu_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_press_pa      (o_out.press_pa),
    .i_press_invalid (o_out.press_invalid),
    .i_hum_q10       (o_out.hum_q10)
);
